// File: src/stli_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stli_pkg: shared types and constants
// Command codes, word structs and cell link types for the sorted table.
// ----------------------------------------------------------------------------
package stli_pkg;

  localparam int TableDepth = 32;
  localparam int DataWidth  = 16;
  localparam int CountWidth = 6;
  localparam int IdxWidth   = $clog2(TableDepth);

  typedef enum logic [1:0] {
    CMD_CLEAR = 2'd0,
    CMD_ADD   = 2'd1,
    CMD_SORT  = 2'd2,
    CMD_QUERY = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_MUL,
    ST_DIV,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic [1:0]                  command;
    logic signed [DataWidth-1:0] key_in;
    logic signed [DataWidth-1:0] value_in;
  } in_word_t;

  typedef struct packed {
    logic signed [DataWidth-1:0] result_value;
    logic                        status;
    logic [CountWidth-1:0]       entry_count;
  } out_word_t;

  // control broadcast from the sequencer to every cell
  typedef struct packed {
    logic                        ins;    // insert pass
    logic                        shift;  // rotate row by one for scan
    logic signed [DataWidth-1:0] key;
    logic signed [DataWidth-1:0] val;
  } cell_ctl_t;

  // entry handed between neighbors
  typedef struct packed {
    logic signed [DataWidth-1:0] key;
    logic signed [DataWidth-1:0] val;
  } entry_t;

endpackage
`default_nettype wire

// File: src/stli_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stli_cell: one table slot
// Holds one entry. On insert, takes the left neighbor's entry or the new one
// so the row stays in key order; on scan, rotates the row toward slot 0.
// ----------------------------------------------------------------------------
module stli_cell (
  input  wire logic                clk,
  input  wire stli_pkg::cell_ctl_t ctl,
  input  wire logic                used,       // this slot holds an entry
  input  wire logic                left_used,
  input  wire stli_pkg::entry_t    left_ent,
  input  wire stli_pkg::entry_t    right_ent,
  output      stli_pkg::entry_t    ent
);
  import stli_pkg::*;

  logic gt_self;
  logic gt_left;

  assign gt_self = used && (ent.key > ctl.key);
  assign gt_left = left_used && (left_ent.key > ctl.key);

  always_ff @(posedge clk) begin
    if (ctl.ins) begin
      // shift up when left is bigger, take the new word at the boundary
      if (gt_left) begin
        ent <= left_ent;
      end else if (gt_self || !used) begin
        ent.key <= ctl.key;
        ent.val <= ctl.val;
      end
    end else if (ctl.shift) begin
      ent <= right_ent;
    end
  end

endmodule
`default_nettype wire

// File: src/stli_div.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// stli_div: restoring divider
// Unsigned 34 by 17 bit division, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module stli_div (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                go,
  input  wire logic [2*stli_pkg::DataWidth+1:0]    num,
  input  wire logic [stli_pkg::DataWidth:0]        den,
  output      logic                                done,
  output      logic [2*stli_pkg::DataWidth+1:0]    quo
);
  import stli_pkg::*;

  localparam int NW = 2*DataWidth+2;
  localparam int DW = DataWidth+1;

  logic [DW:0]            rem;
  logic [DW-1:0]          dvs;
  logic [$clog2(NW+1)-1:0] cnt;
  logic                   run;
  logic [DW:0]            trial;
  logic [DW:0]            diff;

  assign trial = {rem[DW-1:0], quo[NW-1]};
  assign diff  = trial - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      run  <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (go) begin
        run <= 1'b1;
        cnt <= ($clog2(NW+1))'(NW);
      end else if (run) begin
        cnt <= cnt - 1'b1;
        if (cnt == ($clog2(NW+1))'(1)) begin
          run  <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      rem <= '0;
      quo <= num;
      dvs <= den;
    end else if (run) begin
      if (!diff[DW]) begin
        rem <= diff;
        quo <= {quo[NW-2:0], 1'b1};
      end else begin
        rem <= trial;
        quo <= {quo[NW-2:0], 1'b0};
      end
    end
  end

endmodule
`default_nettype wire

// File: src/sorted_table_linear_interpolator.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sorted_table_linear_interpolator: calibration table with interpolation
// Sorted (key, value) row of cells with a serial divider for queries.
// ----------------------------------------------------------------------------
// Usage: drive command/key_in/value_in in the in_word struct with start high
// while busy is low; the word is taken at that edge. One result word follows
// on out_word with strobe high for a single cycle; the receiver cannot stall.
// Clear, add and sort go straight to the done state (add inserts at the accept
// edge; all cells compare in parallel). A query on a non-empty, sorted table
// whose key lies strictly between the end keys rotates the cell row toward
// slot 0 through a full turn, passes the multiply state, then runs the
// bit-serial divider (34 quotient bits, then a done pulse). Queries that pass
// through or clamp go straight to the done state. One item is in work at a
// time; busy is high throughout.
// Rotation leaves the row in order again once a full turn completes: the scan
// always continues for exactly count steps so the row returns home.
// Reset empties the table and marks it sorted; stored entries are not
// cleared since slots above the count are never read.
// ----------------------------------------------------------------------------
module sorted_table_linear_interpolator (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire stli_pkg::in_word_t   in_word,
  output      logic                 busy,
  output      logic                 strobe,
  output      stli_pkg::out_word_t  out_word
);
  import stli_pkg::*;

  localparam int NW = 2*DataWidth+2;

  state_t state, state_next;
  logic [CountWidth-1:0] count;
  logic                  sorted_flag;
  in_word_t              cur;
  logic [CountWidth-1:0] steps;     // rotations done
  logic                  found;
  entry_t                seg0, seg1;
  logic [NW-1:0]         prod;
  logic                  neg;
  logic                  div_go, div_done;
  logic [NW-1:0]         quo;
  logic signed [DataWidth-1:0] res;
  logic                  stat;

  entry_t    ents [TableDepth];
  cell_ctl_t ctl;
  logic      accept;

  assign accept = start && !busy;
  assign busy   = (state != ST_IDLE);

  always_comb begin
    ctl.ins   = accept && (in_word.command == CMD_ADD)
                && (count < CountWidth'(TableDepth));
    ctl.shift = (state == ST_SCAN);
    ctl.key   = in_word.key_in;
    ctl.val   = in_word.value_in;
  end

  for (genvar g = 0; g < TableDepth; g++) begin : g_cell
    stli_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .used      (CountWidth'(g) < count),
      .left_used (g > 0 ? (CountWidth'(g-1) < count) : 1'b0),
      .left_ent  (g > 0 ? ents[(g+TableDepth-1)%TableDepth] : ents[0]),
      .right_ent (CountWidth'(g) == count - 1'b1 ? ents[0]
                  : ents[(g+1)%TableDepth]),
      .ent       (ents[g])
    );
  end

  // segment test at the head of the rotating row
  logic in_seg;
  assign in_seg = (cur.key_in >= ents[0].key) && (cur.key_in <= ents[1].key);

  logic [DataWidth:0] dk, dx, dv;
  assign dk = {seg1.key[DataWidth-1], seg1.key} - {seg0.key[DataWidth-1], seg0.key};
  assign dx = {cur.key_in[DataWidth-1], cur.key_in}
              - {seg0.key[DataWidth-1], seg0.key};
  assign dv = neg ? ({seg0.val[DataWidth-1], seg0.val} - {seg1.val[DataWidth-1], seg1.val})
                  : ({seg1.val[DataWidth-1], seg1.val} - {seg0.val[DataWidth-1], seg0.val});

  // divider loads the product at the end of the multiply cycle
  assign prod = NW'(dx) * NW'(dv);

  stli_div u_div (
    .clk  (clk),
    .rst  (rst),
    .go   (div_go),
    .num  (prod),
    .den  (dk),
    .done (div_done),
    .quo  (quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  logic scan_end;
  assign scan_end = (steps == count - 1'b1);

  always_comb begin
    state_next = state;
    div_go     = 1'b0;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          if (in_word.command == CMD_QUERY && count != '0 && sorted_flag
              && in_word.key_in > ents[0].key
              && in_word.key_in < ents[IdxWidth'(count - 1'b1)].key) begin
            state_next = ST_SCAN;
          end else begin
            state_next = ST_DONE;
          end
        end
      end
      ST_SCAN:  if (scan_end) state_next = ST_MUL;
      ST_MUL: begin
        state_next = ST_DIV;
        div_go     = 1'b1;
      end
      ST_DIV:   if (div_done) state_next = ST_DONE;
      ST_DONE:  state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count       <= '0;
      sorted_flag <= 1'b1;
      strobe      <= 1'b0;
    end else begin
      strobe <= (state == ST_DONE);
      if (accept) begin
        case (in_word.command)
          CMD_CLEAR: begin
            count       <= '0;
            sorted_flag <= 1'b1;
          end
          CMD_ADD: begin
            if (count < CountWidth'(TableDepth)) begin
              count       <= count + 1'b1;
              sorted_flag <= 1'b0;
            end
          end
          CMD_SORT: if (count >= CountWidth'(2)) sorted_flag <= 1'b1;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur   <= in_word;
      steps <= '0;
      found <= 1'b0;
      stat  <= (in_word.command == CMD_ADD) && (count >= CountWidth'(TableDepth));
      res   <= '0;
      if (in_word.command == CMD_QUERY) begin
        if (count == '0 || !sorted_flag) res <= in_word.key_in;
        else if (in_word.key_in <= ents[0].key) res <= ents[0].val;
        else res <= ents[IdxWidth'(count - 1'b1)].val;
      end
    end
    if (state == ST_SCAN) begin
      steps <= steps + 1'b1;
      if (!found && in_seg && !scan_end) begin
        found <= 1'b1;
        seg0  <= ents[0];
        seg1  <= ents[1];
        neg   <= ents[1].val < ents[0].val;
      end
    end
    if (state == ST_DIV && div_done) begin
      if ($signed(dk) <= 0) res <= seg0.val;
      else if (neg) res <= seg0.val - DataWidth'(quo);
      else res <= seg0.val + DataWidth'(quo);
    end
    if (state == ST_DONE) begin
      out_word.result_value <= res;
      out_word.status       <= stat;
      out_word.entry_count  <= count;
    end
  end

  a_strobe_idle: assert property (@(posedge clk) disable iff (rst)
    strobe |-> state == ST_IDLE) else $error("strobe outside idle");
  a_count_max: assert property (@(posedge clk) disable iff (rst)
    count <= CountWidth'(TableDepth)) else $error("count overflow");
  a_div_scan: assert property (@(posedge clk) disable iff (rst)
    div_go |-> found) else $error("divide without segment");

endmodule
`default_nettype wire

// File: tb/sorted_table_linear_interpolator_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_table_linear_interpolator_test: self-checking bench for the table
// Drives clear/add/sort/query words, predicts each result word from a local
// copy of the sorted table and compares every field of each strobed word.
// ----------------------------------------------------------------------------
module sorted_table_linear_interpolator_test;
  import stli_pkg::*;

  localparam int WatchdogLimit = 20000;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      start = 1'b0;
  in_word_t  in_word = '0;
  logic      busy;
  logic      strobe;
  out_word_t out_word;

  sorted_table_linear_interpolator i_dut (
    .clk(clk), .rst(rst), .start(start), .in_word(in_word),
    .busy(busy), .strobe(strobe), .out_word(out_word)
  );

  always #5 clk = ~clk;

  // predictor state
  logic signed [DataWidth-1:0] tbl_key [TableDepth];
  logic signed [DataWidth-1:0] tbl_val [TableDepth];
  int   tbl_count = 0;
  bit   tbl_sorted = 1'b1;

  in_word_t  pending_words [$];
  out_word_t expected_words [$];
  int  errors = 0;
  int  quiet_cycles = 0;
  bit  no_gaps = 1'b0;
  bit  taken = 1'b0;

  function automatic logic signed [DataWidth-1:0] interpolate(
    input logic signed [DataWidth-1:0] x);
    longint k0, k1, v0, v1, q;
    if (tbl_count == 0 || !tbl_sorted) return x;
    if (x <= tbl_key[0]) return tbl_val[0];
    if (x >= tbl_key[tbl_count-1]) return tbl_val[tbl_count-1];
    for (int i = 0; i + 1 < tbl_count; i++) begin
      if (x >= tbl_key[i] && x <= tbl_key[i+1]) begin
        k0 = tbl_key[i]; k1 = tbl_key[i+1];
        v0 = tbl_val[i]; v1 = tbl_val[i+1];
        if (k1 <= k0) return v0;
        // magnitudes are non-negative, so integer divide truncates toward zero
        q = ((longint'(x) - k0) * (v1 >= v0 ? v1 - v0 : v0 - v1)) / (k1 - k0);
        return (v1 >= v0) ? DataWidth'(v0 + q) : DataWidth'(v0 - q);
      end
    end
    return x;
  endfunction

  function automatic out_word_t table_step(input in_word_t w);
    out_word_t r;
    int p;
    r = '0;
    case (cmd_t'(w.command))
      CMD_CLEAR: begin
        tbl_count = 0;
        tbl_sorted = 1'b1;
      end
      CMD_ADD: begin
        if (tbl_count >= TableDepth) begin
          r.status = 1'b1;
        end else begin
          p = tbl_count;
          while (p > 0 && tbl_key[p-1] > w.key_in) begin
            tbl_key[p] = tbl_key[p-1];
            tbl_val[p] = tbl_val[p-1];
            p--;
          end
          tbl_key[p] = w.key_in;
          tbl_val[p] = w.value_in;
          tbl_count++;
          tbl_sorted = 1'b0;
        end
      end
      CMD_SORT: begin
        if (tbl_count >= 2) tbl_sorted = 1'b1;
      end
      default: r.result_value = interpolate(w.key_in);
    endcase
    r.entry_count = CountWidth'(tbl_count);
    return r;
  endfunction

  function automatic in_word_t make_word(input cmd_t c, input int k, input int v);
    in_word_t w;
    w.command = c;
    w.key_in = DataWidth'(k);
    w.value_in = DataWidth'(v);
    return w;
  endfunction

  function automatic int rand_data();
    case ($urandom_range(0, 5))
      0: return -32768;
      1: return 32767;
      2: return $urandom_range(0, 40) - 20;
      default: return int'($urandom);
    endcase
  endfunction

  // driver: hold start until the word is taken
  always @(negedge clk) begin
    if (!rst) begin
      if (!start || taken) begin
        if (pending_words.size() > 0 && (no_gaps || $urandom_range(0, 99) >= 29)) begin
          in_word <= pending_words.pop_front();
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor: sample handshakes and results at the rising edge
  always @(posedge clk) begin
    bit seen;
    seen = 1'b0;
    if (rst) begin
      taken <= 1'b0;
      quiet_cycles <= 0;
    end else begin
      taken <= start && !busy && !taken;
      if (start && !busy && !taken) begin
        expected_words.push_back(table_step(in_word));
        seen = 1'b1;
      end
      if (strobe) begin
        seen = 1'b1;
        if (expected_words.size() == 0) begin
          $display("%0t: unexpected result word %p", $time, out_word);
          errors++;
        end else begin
          out_word_t e;
          e = expected_words.pop_front();
          if (out_word.result_value !== e.result_value)
            $display("%0t: result_value expected %0d actual %0d", $time,
                     e.result_value, out_word.result_value);
          if (out_word.status !== e.status)
            $display("%0t: status expected %0d actual %0d", $time, e.status,
                     out_word.status);
          if (out_word.entry_count !== e.entry_count)
            $display("%0t: entry_count expected %0d actual %0d", $time,
                     e.entry_count, out_word.entry_count);
          if (out_word !== e) errors++;
        end
      end
      quiet_cycles <= seen ? 0 : quiet_cycles + 1;
      if (quiet_cycles >= WatchdogLimit) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    int n, k;
    // directed: pass-through on empty, extremes, equal keys, full table
    pending_words.push_back(make_word(CMD_QUERY, 123, 0));
    pending_words.push_back(make_word(CMD_SORT, 0, 0));
    pending_words.push_back(make_word(CMD_ADD, 100, -32768));
    pending_words.push_back(make_word(CMD_SORT, 0, 0));
    pending_words.push_back(make_word(CMD_QUERY, -5, 0));
    pending_words.push_back(make_word(CMD_ADD, -32768, 32767));
    pending_words.push_back(make_word(CMD_QUERY, 7, 0));
    pending_words.push_back(make_word(CMD_ADD, 32767, -32768));
    pending_words.push_back(make_word(CMD_ADD, 100, 500));
    pending_words.push_back(make_word(CMD_SORT, 0, 0));
    pending_words.push_back(make_word(CMD_QUERY, -32768, 0));
    pending_words.push_back(make_word(CMD_QUERY, 32767, 0));
    pending_words.push_back(make_word(CMD_QUERY, 100, 0));
    pending_words.push_back(make_word(CMD_QUERY, -1, 0));
    pending_words.push_back(make_word(CMD_QUERY, 20000, 0));
    pending_words.push_back(make_word(CMD_CLEAR, -1, -1));
    for (int i = 0; i < 33; i++)
      pending_words.push_back(make_word(CMD_ADD, 2000 * i - 32000, rand_data()));
    pending_words.push_back(make_word(CMD_SORT, 0, 0));
    pending_words.push_back(make_word(CMD_QUERY, 1234, 0));
    // random: mostly fill, sort, then a run of queries
    while (pending_words.size() < 600) begin
      pending_words.push_back(make_word(CMD_CLEAR, rand_data(), rand_data()));
      n = $urandom_range(0, 9) == 0 ? $urandom_range(30, 34) : $urandom_range(0, 8);
      for (int i = 0; i < n; i++)
        pending_words.push_back(make_word(CMD_ADD, rand_data(), rand_data()));
      if ($urandom_range(0, 5) != 0)
        pending_words.push_back(make_word(CMD_SORT, rand_data(), rand_data()));
      k = $urandom_range(2, 12);
      for (int i = 0; i < k; i++)
        pending_words.push_back(make_word(cmd_t'($urandom_range(0, 9) == 0 ?
          $urandom_range(1, 2) : 3), rand_data(), rand_data()));
    end
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    repeat (200) @(posedge clk);
    no_gaps = 1'b1;
    repeat (3000) @(posedge clk);
    no_gaps = 1'b0;
    while (pending_words.size() > 0 || start) @(posedge clk);
    while (expected_words.size() > 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: sim.f
src/stli_pkg.sv
src/stli_cell.sv
src/stli_div.sv
src/sorted_table_linear_interpolator.sv
tb/sorted_table_linear_interpolator_test.sv
